// ===== design/assert_macros.svh =====
// Assertion macros shared by the tilt averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tav_pkg.sv =====
// Shared constants and the angle lookup table for the tilt averager.
package tav_pkg;

    localparam int AXES        = 3;
    localparam int RAW_W       = 8;
    localparam int ANGLE_IDX_W = 6;
    localparam int ANGLE_DEPTH = 64;
    localparam int ANGLE_W     = 7;
    localparam int ANGLE_MAX   = 90;
    localparam int CHAR_W      = 6;
    localparam int DIGIT_W     = 4;
    localparam int DEC_BASE    = 10;
    localparam int TENS_MAX    = 9;
    localparam int WINDOW_DEF  = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

    // Stream widths: input bytes packed x,y,z; result padded to whole bytes.
    localparam int S_DATA_W   = AXES * RAW_W;
    localparam int M_FIELDS_W = AXES * ANGLE_W + 2 * AXES * CHAR_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [ANGLE_W-1:0] ANGLE_LUT [ANGLE_DEPTH] = '{
        7'd0,  7'd3,  7'd5,  7'd8,  7'd11, 7'd14, 7'd16, 7'd19,
        7'd22, 7'd25, 7'd28, 7'd31, 7'd34, 7'd38, 7'd41, 7'd45,
        7'd49, 7'd53, 7'd58, 7'd63, 7'd70, 7'd80, 7'd90, 7'd90,
        7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90,
        7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90,
        7'd90, 7'd90, 7'd90, 7'd80, 7'd70, 7'd63, 7'd58, 7'd53,
        7'd49, 7'd45, 7'd41, 7'd38, 7'd34, 7'd31, 7'd28, 7'd25,
        7'd22, 7'd19, 7'd16, 7'd14, 7'd11, 7'd8,  7'd5,  7'd3
    };

endpackage

// ===== design/tilt_angle_average_to_ascii.sv =====
// Top level of the tilt angle averager with ASCII digit output.
// Each input transfer carries three raw tilt bytes; bits 5..0 of each select an
// angle of 0..90 degrees. Per axis the block keeps the last WINDOW angles
// (zero after reset, so the mean ramps up during the first WINDOW samples) and
// returns one result per input: the truncated mean of each axis and that mean
// as two ASCII digits. One transfer is accepted every cycle while the result
// side is not stalled; a result passes through the input register, then the
// result register. The history lives in a WINDOW-row memory whose registered read
// prefetches the row to be replaced next, so the one write-and-read port per
// cycle sets the one-item-per-cycle rate.
`include "assert_macros.svh"

module tilt_angle_average_to_ascii #(
    parameter int WINDOW = tav_pkg::WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // raw_x[7:0], raw_y[15:8], raw_z[23:16]
    input  logic [tav_pkg::S_DATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // mean_x[6:0], mean_y[13:7], mean_z[20:14], x_tens_char[26:21],
    // x_ones_char[32:27], y_tens_char[38:33], y_ones_char[44:39],
    // z_tens_char[50:45], z_ones_char[56:51], zero pad above
    output logic [tav_pkg::M_DATA_W-1:0]  m_axis_tdata
);
    import tav_pkg::*;

    logic                               in_valid_reg;
    logic [AXES-1:0][RAW_W-1:0]         in_raw_reg;
    logic                               out_valid_reg;
    logic [M_DATA_W-1:0]                out_data_reg;
    logic [M_DATA_W-1:0]                out_data_next;
    logic                               adv;
    logic [AXES-1:0][ANGLE_W-1:0]       mean;
    logic [AXES-1:0][CHAR_W-1:0]        tens_char;
    logic [AXES-1:0][CHAR_W-1:0]        ones_char;

    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    tav_avg #(
        .WINDOW (WINDOW)
    ) u_avg (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .raw   (in_raw_reg),
        .mean  (mean)
    );

    for (genvar a = 0; a < AXES; a++)
    begin : g_digits
        tav_digits u_digits (
            .mean      (mean[a]),
            .tens_char (tens_char[a]),
            .ones_char (ones_char[a])
        );
    end

    always_comb
    begin
        out_data_next = M_DATA_W'({ones_char[2], tens_char[2],
                                   ones_char[1], tens_char[1],
                                   ones_char[0], tens_char[0],
                                   mean[2], mean[1], mean[0]});
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_raw_reg <= s_axis_tdata;
        end
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_CLK(a_mean_x_range, m_axis_tvalid |-> m_axis_tdata[6:0] <= 7'(ANGLE_MAX), "mean_x above 90")
    `ASSERT_CLK(a_x_tens_digit, m_axis_tvalid |-> (m_axis_tdata[26:21] >= ASCII_ZERO && m_axis_tdata[26:21] <= ASCII_ZERO + 6'(TENS_MAX)), "x tens char not a digit")

endmodule

// ===== design/tav_avg.sv =====
// Angle lookup, per-axis history ring, running sums and divide by window.
`include "assert_macros.svh"

module tav_avg #(
    parameter int WINDOW = tav_pkg::WINDOW_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            adv,
    input  logic [tav_pkg::AXES-1:0][tav_pkg::RAW_W-1:0]    raw,
    output logic [tav_pkg::AXES-1:0][tav_pkg::ANGLE_W-1:0]  mean
);
    import tav_pkg::*;

    localparam int IDX_W   = $clog2(WINDOW);
    localparam int SUM_W   = $clog2(ANGLE_MAX * WINDOW + 1);
    localparam int SHIFT   = SUM_W + IDX_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int RECIP   = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int SUM_MAX = ANGLE_MAX * WINDOW;

    typedef logic [AXES-1:0][ANGLE_W-1:0] row_t;

    row_t                  mem [WINDOW];
    row_t                  rd_row_reg;
    logic                  rd_valid_reg;
    logic [WINDOW-1:0]     valid_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [IDX_W-1:0]      pos_next;
    logic [SUM_W-1:0]      sum_reg  [AXES];
    logic [SUM_W-1:0]      sum_next [AXES];
    row_t                  ang;
    row_t                  old;
    logic [PROD_W-1:0]     prod     [AXES];

    assign pos_next = (pos_reg == IDX_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            ang[a]      = ANGLE_LUT[raw[a][ANGLE_IDX_W-1:0]];
            old[a]      = rd_valid_reg ? rd_row_reg[a] : '0;
            sum_next[a] = sum_reg[a] - SUM_W'(old[a]) + SUM_W'(ang[a]);
            // exact floor(sum / WINDOW) by reciprocal over the whole sum range
            prod[a]     = PROD_W'(sum_next[a]) * PROD_W'(RECIP);
            mean[a]     = ANGLE_W'(prod[a] >> SHIFT);
        end
    end

    // Prefetch the row that the following transfer will replace.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mem[pos_reg] <= ang;
            rd_row_reg   <= mem[pos_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else if (adv)
        begin
            pos_reg            <= pos_next;
            valid_reg[pos_reg] <= 1'b1;
            rd_valid_reg       <= valid_reg[pos_next];
            for (int a = 0; a < AXES; a++)
            begin
                sum_reg[a] <= sum_next[a];
            end
        end
    end

    `ASSERT_CLK(a_pos_range, pos_reg <= IDX_W'(WINDOW - 1), "write position out of range")
    `ASSERT_CLK(a_pos_step, adv |=> pos_reg == $past(pos_next), "write position did not advance")
    `ASSERT_CLK(a_sum_x, sum_reg[0] <= SUM_W'(SUM_MAX), "x running sum exceeds window maximum")
    `ASSERT_CLK(a_sum_z, sum_reg[2] <= SUM_W'(SUM_MAX), "z running sum exceeds window maximum")

endmodule

// ===== design/tav_digits.sv =====
// Splits a 0..99 mean into ASCII tens and ones characters.
module tav_digits (
    input  logic [tav_pkg::ANGLE_W-1:0] mean,
    output logic [tav_pkg::CHAR_W-1:0]  tens_char,
    output logic [tav_pkg::CHAR_W-1:0]  ones_char
);
    import tav_pkg::*;

    logic [DIGIT_W-1:0] tens;
    logic [ANGLE_W-1:0] rem;

    always_comb
    begin
        tens = '0;
        for (int k = 1; k <= TENS_MAX; k++)
        begin
            if (mean >= ANGLE_W'(k * DEC_BASE))
            begin
                tens = DIGIT_W'(k);
            end
        end
        rem       = mean - ANGLE_W'(tens) * ANGLE_W'(DEC_BASE);
        tens_char = ASCII_ZERO + CHAR_W'(tens);
        ones_char = ASCII_ZERO + CHAR_W'(rem[DIGIT_W-1:0]);
    end

endmodule

// ===== tb/tilt_angle_average_to_ascii_tb.sv =====
// Self-checking testbench for the tilt angle averager with ASCII digit output.
`timescale 1ns / 1ps

module tilt_angle_average_to_ascii_tb;

    import tav_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int RESET_CYC  = 6;
    localparam int AVG_DEPTH  = 8;
    localparam int HOLD_LEN   = 200;
    localparam int DRAIN_CYC  = 10;
    localparam int MAX_REPORT = 10;

    localparam logic [5:0] CHAR_ZERO = 6'h30;

    // degrees per 6-bit tilt code
    localparam bit [6:0] TILT_DEG [64] = '{
        7'd0,  7'd3,  7'd5,  7'd8,  7'd11, 7'd14, 7'd16, 7'd19,
        7'd22, 7'd25, 7'd28, 7'd31, 7'd34, 7'd38, 7'd41, 7'd45,
        7'd49, 7'd53, 7'd58, 7'd63, 7'd70, 7'd80, 7'd90, 7'd90,
        7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90,
        7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90, 7'd90,
        7'd90, 7'd90, 7'd90, 7'd80, 7'd70, 7'd63, 7'd58, 7'd53,
        7'd49, 7'd45, 7'd41, 7'd38, 7'd34, 7'd31, 7'd28, 7'd25,
        7'd22, 7'd19, 7'd16, 7'd14, 7'd11, 7'd8,  7'd5,  7'd3
    };

    typedef struct packed {
        logic [2:0][6:0] mean;
        logic [2:0][5:0] tens;
        logic [2:0][5:0] ones;
    } tilt_avg_t;

    class tilt_avg_scoreboard;
        bit [6:0]  angle_ring [3][AVG_DEPTH];
        bit [9:0]  angle_sum [3];
        int        ring_pos;
        tilt_avg_t avg_queue [$];
        int        mismatches;

        function new();
            for (int a = 0; a < 3; a++)
            begin
                angle_sum[a] = '0;
                for (int i = 0; i < AVG_DEPTH; i++)
                    angle_ring[a][i] = '0;
            end
            ring_pos   = 0;
            mismatches = 0;
        endfunction

        // accepted input transfer: update the window and queue the averages
        function void note_sample(logic [7:0] raw_x, logic [7:0] raw_y, logic [7:0] raw_z);
            logic [2:0][7:0] raw;
            tilt_avg_t       avg;
            bit [6:0]        deg;
            int              m;
            raw = {raw_z, raw_y, raw_x};
            for (int a = 0; a < 3; a++)
            begin
                deg = TILT_DEG[raw[a][5:0]];
                angle_sum[a] = angle_sum[a] - angle_ring[a][ring_pos] + deg;
                angle_ring[a][ring_pos] = deg;
                m = angle_sum[a] / AVG_DEPTH;
                avg.mean[a] = 7'(m);
                avg.tens[a] = CHAR_ZERO + 6'(m / 10);
                avg.ones[a] = CHAR_ZERO + 6'(m % 10);
            end
            ring_pos = (ring_pos == AVG_DEPTH - 1) ? 0 : ring_pos + 1;
            avg_queue.push_back(avg);
        endfunction

        function void report(string what, int exp_v, int act_v);
            mismatches++;
            if (mismatches <= MAX_REPORT)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, act_v);
        endfunction

        function void check_average(logic [M_DATA_W-1:0] data);
            tilt_avg_t exp_avg;
            tilt_avg_t got;
            string     axis_name [3];
            axis_name = '{"x", "y", "z"};
            for (int a = 0; a < 3; a++)
            begin
                got.mean[a] = data[7*a +: 7];
                got.tens[a] = data[21 + 12*a +: 6];
                got.ones[a] = data[27 + 12*a +: 6];
            end
            if (avg_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("%0t: unexpected result transfer, data %h", $time, data);
                return;
            end
            exp_avg = avg_queue.pop_front();
            for (int a = 0; a < 3; a++)
            begin
                if (got.mean[a] !== exp_avg.mean[a])
                    report({"mean_", axis_name[a]}, exp_avg.mean[a], got.mean[a]);
                if (got.tens[a] !== exp_avg.tens[a])
                    report({axis_name[a], "_tens_char"}, exp_avg.tens[a], got.tens[a]);
                if (got.ones[a] !== exp_avg.ones[a])
                    report({axis_name[a], "_ones_char"}, exp_avg.ones[a], got.ones[a]);
            end
        endfunction

        function int pending();
            return avg_queue.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;

    tilt_avg_scoreboard sb;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;

    tilt_angle_average_to_ascii i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // result side: check each transfer, then pick tready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_average(m_axis_tdata);
            if (hold_req)
            begin
                hold_left = HOLD_LEN;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_sample(input logic [7:0] raw_x, input logic [7:0] raw_y,
                               input logic [7:0] raw_z);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {raw_z, raw_y, raw_x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_sample(raw_x, raw_y, raw_z);
    endtask

    // random samples; some runs hold one tilt code per axis so the mean settles
    task automatic send_random(input int count);
        int             streak_left;
        bit             steady;
        logic [5:0]     steady_code [3];
        logic [7:0]     raw [3];
        streak_left = 0;
        steady      = 1'b0;
        for (int n = 0; n < count; n++)
        begin
            if (streak_left == 0)
            begin
                streak_left = $urandom_range(12, 1);
                steady      = ($urandom_range(2) != 0);
                for (int a = 0; a < 3; a++)
                    steady_code[a] = 6'($urandom_range(63));
            end
            for (int a = 0; a < 3; a++)
                raw[a] = steady ? {2'($urandom_range(3)), steady_code[a]}
                                : 8'($urandom_range(255));
            streak_left--;
            send_sample(raw[0], raw[1], raw[2]);
        end
    endtask

    // stop offering, then wait until every expected result has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int src_pct [4];
        int snk_pct [4];
        src_pct = '{0, 52, 0, 10};
        snk_pct = '{0, 0, 52, 10};
        sb = new();
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // warm-up ramp to full scale, upper bits toggled along the way
        for (int i = 0; i < 8; i++)
            send_sample(8'h16 | 8'(i << 6), 8'h16 | 8'((3 - i % 4) << 6), 8'h16);
        // back down to zero through codes that differ only in bits 7..6
        for (int i = 0; i < 8; i++)
            send_sample(8'(i % 4) << 6, 8'hC0, 8'h40);
        // table ends and knee points, plus all-ones bytes
        send_sample(8'hFF, 8'h3F, 8'h01);
        send_sample(8'h15, 8'h2B, 8'h20);
        send_sample(8'hAA, 8'h55, 8'hFF);
        send_sample(8'h2A, 8'h16, 8'h17);
        send_sample(8'h7F, 8'hBF, 8'h3E);
        send_sample(8'h13, 8'h14, 8'h2C);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct  = src_pct[p];
            snk_stall_pct = snk_pct[p];
            if (p == 0)
                hold_req = 1'b1;
            send_random(200);
            wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYC) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
